[hdl/i2c_bit_bang_master_top_assert.svh]
// assertion macros for the i2c bit-bang master top level
`ifndef I2C_BIT_BANG_MASTER_TOP_ASSERT_SVH
`define I2C_BIT_BANG_MASTER_TOP_ASSERT_SVH

// same-cycle implication, checked on aclk outside reset
`define I2CBB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cbb check failed");

// next-cycle implication, checked on aclk outside reset
`define I2CBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cbb check failed");

`endif

[hdl/i2cbb_pkg.sv]
package i2cbb_pkg;

    // default width of the phase delay counter
    localparam int DELAY_WIDTH_DEF = 16;

    // field widths
    localparam int TICKS_W = 16;
    localparam int LEN_W   = 16;
    localparam int CFG_ADDR_W = 2;

    // item kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    // transfer modes, the spare code runs as a write with stop
    localparam logic [1:0] MODE_READ         = 2'd0;
    localparam logic [1:0] MODE_WRITE        = 2'd1;
    localparam logic [1:0] MODE_WRITE_NOSTOP = 2'd2;
    localparam logic [1:0] MODE_SPARE        = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
    localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

    // read/write bit handling of the address byte
    localparam logic [7:0] RD_BIT  = 8'h01;
    localparam logic [7:0] WR_MASK = 8'hFE;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL_TICKS  = 2'd1;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd4;

    // bus sequencer phases
    typedef enum logic [4:0] {
        P_IDLE, P_START_A, P_START_B, P_START_C,
        P_WB_LOW, P_WB_HIGH, P_WB_END, P_ACK_REL, P_ACK_HIGH, P_ACK_SAMPLE,
        P_NEED, P_RD_PREP, P_RD_HIGH, P_RD_SAMPLE, P_RD_ACK, P_RD_ACK_HIGH,
        P_RD_ACK_LOW, P_STOP_A, P_STOP_B, P_STOP_C, P_FINISH,
        P_OFF_WAIT, P_OFF_HIGH
    } phase_t;

    // timing configuration
    typedef struct packed {
        logic [TICKS_W-1:0] phase_ticks;
        logic [TICKS_W-1:0] tail_ticks;
    } cfg_t;

    // one input transaction
    typedef struct packed {
        logic [1:0]       op;
        logic             sda_in;
        logic [1:0]       mode;
        logic [7:0]       device_address;
        logic [LEN_W-1:0] transfer_length;
        logic [7:0]       write_byte;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       need_data;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [1:0] status;
    } res_t;

endpackage

[hdl/i2cbb_engine.sv]
module i2cbb_engine #(
    parameter int DELAY_WIDTH = i2cbb_pkg::DELAY_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  i2cbb_pkg::item_t  item,
    input  i2cbb_pkg::cfg_t   cfg,
    output i2cbb_pkg::res_t   res
);
    import i2cbb_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] delay_reg, delay_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [LEN_W-1:0]       bytes_reg, bytes_next;
    logic [1:0]             mode_reg, mode_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic [1:0]             status_reg, status_next;
    logic                   addr_byte_reg, addr_byte_next;
    logic                   rv, done;
    logic                   act;
    logic                   take_data;
    logic                   take_begin;
    logic [1:0]             mode_eff;
    logic [DELAY_WIDTH-1:0] ld_phase, ld_tail;

    assign ld_phase = DELAY_WIDTH'(cfg.phase_ticks);
    assign ld_tail  = DELAY_WIDTH'(cfg.tail_ticks);
    assign mode_eff = (item.mode == MODE_SPARE) ? MODE_WRITE : item.mode;

    // qualified events for this transaction
    assign take_begin = fire && item.op == OP_BEGIN && phase_reg == P_IDLE;
    assign take_data  = fire && item.op == OP_DATA && phase_reg == P_NEED
                        && delay_reg == '0;
    assign act = fire && item.op == OP_TICK && phase_reg != P_IDLE
                 && phase_reg != P_NEED && delay_reg == '0;

    // next phase and delay
    always_comb begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        if (take_begin) begin
            phase_next = P_START_A;
            delay_next = ld_phase;
        end else if (take_data) begin
            phase_next = P_WB_LOW;
            delay_next = '0;
        end else if (fire && item.op == OP_TICK && phase_reg != P_IDLE
                     && delay_reg != '0) begin
            delay_next = delay_reg - DELAY_WIDTH'(1);
        end else if (act) begin
            delay_next = ld_phase;
            case (phase_reg)
                P_START_A: phase_next = P_START_B;
                P_START_B: phase_next = P_START_C;
                P_START_C: begin
                    phase_next = P_WB_LOW;
                    delay_next = '0;
                end
                P_WB_LOW:  phase_next = P_WB_HIGH;
                P_WB_HIGH: phase_next = (bit_reg == 3'd0) ? P_WB_END : P_WB_LOW;
                P_WB_END:  phase_next = P_ACK_REL;
                P_ACK_REL: phase_next = P_ACK_HIGH;
                P_ACK_HIGH: phase_next = P_ACK_SAMPLE;
                P_ACK_SAMPLE: begin
                    if (item.sda_in)
                        phase_next = P_STOP_A;
                    else if (mode_reg == MODE_READ)
                        phase_next = (bytes_reg != '0) ? P_RD_PREP : P_STOP_A;
                    else if (bytes_reg != '0)
                        phase_next = P_NEED;
                    else
                        phase_next = (mode_reg == MODE_WRITE_NOSTOP) ? P_OFF_WAIT : P_STOP_A;
                end
                P_RD_PREP: phase_next = P_RD_HIGH;
                P_RD_HIGH: phase_next = P_RD_SAMPLE;
                P_RD_SAMPLE: begin
                    phase_next = (bit_reg == 3'd0) ? P_RD_ACK : P_RD_HIGH;
                    delay_next = ld_tail;
                end
                P_RD_ACK:      phase_next = P_RD_ACK_HIGH;
                P_RD_ACK_HIGH: phase_next = P_RD_ACK_LOW;
                P_RD_ACK_LOW: begin
                    phase_next = (bytes_reg != '0) ? P_RD_PREP : P_STOP_A;
                    delay_next = '0;
                end
                P_STOP_A: phase_next = P_STOP_B;
                P_STOP_B: phase_next = P_STOP_C;
                P_STOP_C: begin
                    phase_next = P_FINISH;
                    delay_next = ld_tail;
                end
                P_OFF_WAIT: phase_next = P_OFF_HIGH;
                default: begin
                    phase_next = P_IDLE;
                    delay_next = '0;
                end
            endcase
        end
    end

    // line levels, shifter, counters and status
    always_comb begin
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        bytes_next     = bytes_reg;
        mode_next      = mode_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        status_next    = status_reg;
        addr_byte_next = addr_byte_reg;
        rv             = 1'b0;
        done           = 1'b0;
        if (take_begin) begin
            mode_next      = mode_eff;
            bytes_next     = item.transfer_length;
            shift_next     = (mode_eff == MODE_READ) ? (item.device_address | RD_BIT)
                                                     : (item.device_address & WR_MASK);
            status_next    = STATUS_OK;
            addr_byte_next = 1'b1;
        end else if (take_data) begin
            shift_next     = item.write_byte;
            bytes_next     = bytes_reg - LEN_W'(1);
            bit_next       = 3'd7;
            addr_byte_next = 1'b0;
        end else if (act) begin
            case (phase_reg)
                P_START_A: begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                P_START_B: sda_next = 1'b0;
                P_START_C: begin
                    scl_next = 1'b0;
                    bit_next = 3'd7;
                end
                P_WB_LOW: begin
                    scl_next = 1'b0;
                    sda_next = shift_reg[bit_reg];
                end
                P_WB_HIGH: begin
                    scl_next = 1'b1;
                    if (bit_reg != 3'd0) bit_next = bit_reg - 3'd1;
                end
                P_WB_END:   scl_next = 1'b0;
                P_ACK_REL:  sda_next = 1'b1;
                P_ACK_HIGH: scl_next = 1'b1;
                P_ACK_SAMPLE: begin
                    scl_next = 1'b0;
                    if (item.sda_in)
                        status_next = addr_byte_reg ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
                end
                P_RD_PREP: begin
                    sda_next   = 1'b1;
                    shift_next = '0;
                    bit_next   = 3'd7;
                end
                P_RD_HIGH: scl_next = 1'b1;
                P_RD_SAMPLE: begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    scl_next   = 1'b0;
                    if (bit_reg == 3'd0) begin
                        bytes_next = bytes_reg - LEN_W'(1);
                        rv         = 1'b1;
                    end else begin
                        bit_next = bit_reg - 3'd1;
                    end
                end
                P_RD_ACK:      if (bytes_reg != '0) sda_next = 1'b0;
                P_RD_ACK_HIGH: scl_next = 1'b1;
                P_RD_ACK_LOW:  scl_next = 1'b0;
                P_STOP_A:      sda_next = 1'b0;
                P_STOP_B:      scl_next = 1'b1;
                P_STOP_C:      sda_next = 1'b1;
                P_FINISH:      done = 1'b1;
                P_OFF_HIGH: begin
                    scl_next = 1'b1;
                    done     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result of this transaction
    always_comb begin
        res.scl_level  = scl_next;
        res.sda_level  = sda_next;
        res.busy_res   = (phase_next != P_IDLE);
        res.need_data  = (phase_next == P_NEED) && (delay_next == '0);
        res.read_valid = rv;
        res.read_byte  = rv ? shift_next : 8'h00;
        res.done_res   = done;
        res.status     = status_next;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= P_IDLE;
            delay_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            bytes_reg     <= '0;
            mode_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            status_reg    <= STATUS_OK;
            addr_byte_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            bytes_reg     <= bytes_next;
            mode_reg      <= mode_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            status_reg    <= status_next;
            addr_byte_reg <= addr_byte_next;
        end
    end

endmodule

[hdl/i2c_bit_bang_master_top.sv]
// Path: a transaction accepted into the input register is handled by the sequencer,
// and its result is captured in the result register when the output side is free.
// Throughput: one transaction per clock unless m_tready holds back a pending result.
// Reset: aresetn is synchronous and active low; it empties both registers, puts the
// sequencer in idle with both lines released and sets both tick registers to 4.
module i2c_bit_bang_master_top #(
    parameter int DELAY_WIDTH = i2cbb_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sda_in, mode[2:1], device_address[10:3], transfer_length[26:11],
    // write_byte[34:27], zero fill
    input  logic [39:0]                          s_tdata,
    // op
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // scl_level, sda_level, busy_res, need_data, read_valid,
    // read_byte[12:5], done_res, status[15:14]
    output logic [15:0]                          m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2cbb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [i2cbb_pkg::TICKS_W-1:0]        cfg_data
);
    import i2cbb_pkg::*;

`include "i2c_bit_bang_master_top_assert.svh"

    item_t in_reg;
    logic  in_valid_reg;
    res_t  out_reg;
    logic  out_valid_reg;
    cfg_t  cfg_reg;
    res_t  res;
    logic  out_free;
    logic  fire;
    item_t s_item;

    // unpack the input transaction
    assign s_item.op              = s_tuser;
    assign s_item.sda_in          = s_tdata[0];
    assign s_item.mode            = s_tdata[2:1];
    assign s_item.device_address  = s_tdata[10:3];
    assign s_item.transfer_length = s_tdata[26:11];
    assign s_item.write_byte      = s_tdata[34:27];

    // handshake flow
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_reg.status, out_reg.done_res, out_reg.read_byte,
                        out_reg.read_valid, out_reg.need_data, out_reg.busy_res,
                        out_reg.sda_level, out_reg.scl_level};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= s_item;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks <= TICKS_RESET;
            cfg_reg.tail_ticks  <= TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_data;
                CFG_TAIL_TICKS:  cfg_reg.tail_ticks  <= cfg_data;
                default: ;
            endcase
        end
    end

    // bus sequencer
    i2cbb_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // checks
    `I2CBB_ASSERT_NOW(a_done_not_busy, out_valid_reg && out_reg.done_res, !out_reg.busy_res)
    `I2CBB_ASSERT_NOW(a_read_not_need, out_valid_reg && out_reg.read_valid, !out_reg.need_data)
    `I2CBB_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg)

endmodule
